[src/sbpq_pkg.sv]
package sbpq_pkg;

  // Default number of queue slots
  localparam int unsigned QueueDepthDefault = 16;

  // Request codes
  localparam logic ReqInsert = 1'b0;
  localparam logic ReqRemove = 1'b1;

  // Result status codes
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;

  // Request word
  typedef struct packed {
    logic        req_type;
    logic [7:0]  entry_id;
    logic [15:0] address;
  } sbpq_req_t;

  // Result word
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_id;
    logic [15:0] out_address;
    logic        is_empty;
    logic [4:0]  fill_count;
  } sbpq_rsp_t;

  // One stored entry
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] key;
  } sbpq_entry_t;

  // Commands from the controller to the datapath
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_REJ_FULL,
    CMD_REJ_EMPTY,
    CMD_INS_START,
    CMD_INS_SHIFT,
    CMD_INS_PUT,
    CMD_REM_START,
    CMD_REM_TAKE,
    CMD_REM_SHIFT,
    CMD_REM_DONE
  } sbpq_cmd_e;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic key_gt;
    logic scan_last;
    logic shift_last;
    logic head_last;
  } sbpq_stat_t;

endpackage

[src/sorted_breakpoint_priority_queue.sv]
// Sorted breakpoint queue: pulse start while busy is low to hand in one request
// word (insert an id/address pair, or remove the lowest address). Exactly one
// result word follows, shown for one cycle with rsp_valid_o high; it cannot be
// held off, so capture it when the strobe is seen. A rejected request (insert
// when full, remove when empty) returns its result in the cycle after start. An
// insert or a remove takes longer the more entries it must move; the time is set
// by the entry store, which has one read and one write port: entries move one
// slot per cycle to open or close the gap. busy is low again while the strobe
// is shown, so the next request may start in that cycle.
module sorted_breakpoint_priority_queue #(
  parameter int unsigned QUEUE_DEPTH = sbpq_pkg::QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  sbpq_pkg::sbpq_req_t req_i,
  output logic                rsp_valid_o,
  output sbpq_pkg::sbpq_rsp_t rsp_o
);
  import sbpq_pkg::*;

  sbpq_cmd_e  cmd;
  sbpq_stat_t stat;

  // Sequence the scan and shift steps
  sbpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_i.req_type),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  // Hold the entries and build result words
  sbpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .stat_o      (stat),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule

[src/sbpq_ctrl.sv]
module sbpq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               req_type_i,
  input  sbpq_pkg::sbpq_stat_t stat_i,
  output sbpq_pkg::sbpq_cmd_e  cmd_o,
  output logic               busy_o
);
  import sbpq_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_INS_SCAN  = 5'b00010,
    ST_INS_PUT   = 5'b00100,
    ST_REM_HEAD  = 5'b01000,
    ST_REM_SHIFT = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   fin_q, fin_d;

  // Next state and command
  always_comb begin
    state_d = state_q;
    fin_d   = 1'b0;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (req_type_i == ReqInsert) begin
            if (stat_i.full) begin
              cmd_o = CMD_REJ_FULL;
            end else begin
              cmd_o   = CMD_INS_START;
              state_d = stat_i.empty ? ST_INS_PUT : ST_INS_SCAN;
            end
          end else begin
            if (stat_i.empty) begin
              cmd_o = CMD_REJ_EMPTY;
            end else begin
              cmd_o   = CMD_REM_START;
              state_d = ST_REM_HEAD;
            end
          end
        end
      end
      ST_INS_SCAN: begin
        if (stat_i.key_gt) begin
          cmd_o = CMD_INS_SHIFT;
          if (stat_i.scan_last) begin
            state_d = ST_INS_PUT;
          end
        end else begin
          state_d = ST_INS_PUT;
        end
      end
      ST_INS_PUT: begin
        cmd_o   = CMD_INS_PUT;
        state_d = ST_IDLE;
      end
      ST_REM_HEAD: begin
        cmd_o   = CMD_REM_TAKE;
        state_d = ST_REM_SHIFT;
        fin_d   = stat_i.head_last;
      end
      ST_REM_SHIFT: begin
        // finish once the last entry has moved down, or at once for one entry
        if (fin_q) begin
          cmd_o   = CMD_REM_DONE;
          state_d = ST_IDLE;
        end else begin
          cmd_o = CMD_REM_SHIFT;
          fin_d = stat_i.shift_last;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

`ifndef ASSERT_OFF
  // A scan ends in the put step
  a_scan_to_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INS_SCAN && !stat_i.key_gt) |=> (state_q == ST_INS_PUT))
    else $error("insert scan did not move to put");
  // A finished remove returns to idle
  a_rem_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == CMD_REM_DONE) |=> (state_q == ST_IDLE))
    else $error("remove did not return to idle");
  // Rejections leave the controller idle
  a_rej_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o == CMD_REJ_FULL || cmd_o == CMD_REJ_EMPTY) |=> !busy_o)
    else $error("rejection left controller busy");
`endif

endmodule

[src/sbpq_dp.sv]
module sbpq_dp #(
  parameter int unsigned QUEUE_DEPTH = sbpq_pkg::QueueDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbpq_pkg::sbpq_cmd_e  cmd_i,
  input  sbpq_pkg::sbpq_req_t  req_i,
  output sbpq_pkg::sbpq_stat_t stat_o,
  output logic                 rsp_valid_o,
  output sbpq_pkg::sbpq_rsp_t  rsp_o
);
  import sbpq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  sbpq_entry_t store_q [QUEUE_DEPTH];
  sbpq_entry_t rd_q, hold_q, hold_d;
  sbpq_req_t   req_q, req_d;
  logic [CW-1:0] cnt_q, cnt_d, pos_q, pos_d;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          we;
  sbpq_entry_t   wr_data;
  sbpq_rsp_t     rsp_q, rsp_d;
  logic          rsp_valid_q, rsp_valid_d;
  logic [31:0]   cnt_ext;
  logic [CW-1:0] pos_m1, pos_m2, pos_p1, cnt_m1;

  assign pos_m1 = pos_q - CW'(1);
  assign pos_m2 = pos_q - CW'(2);
  assign pos_p1 = pos_q + CW'(1);
  assign cnt_m1 = cnt_q - CW'(1);

  // Status toward the controller
  assign stat_o.full       = (cnt_q == CW'(QUEUE_DEPTH));
  assign stat_o.empty      = (cnt_q == '0);
  assign stat_o.key_gt     = (rd_q.key > req_q.address);
  assign stat_o.scan_last  = (pos_q == CW'(1));
  assign stat_o.shift_last = (pos_q == cnt_m1);
  assign stat_o.head_last  = (cnt_q == CW'(1));

  // Decode the command into memory access, pointer and result
  always_comb begin
    req_d       = req_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    hold_d      = hold_q;
    rd_addr     = pos_q[AW-1:0];
    wr_addr     = pos_q[AW-1:0];
    wr_data     = rd_q;
    we          = 1'b0;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    unique case (cmd_i) inside
      CMD_REJ_FULL, CMD_REJ_EMPTY: begin
        rsp_valid_d = 1'b1;
        rsp_d.status      = (cmd_i == CMD_REJ_FULL) ? StFull : StEmpty;
        rsp_d.out_id      = '0;
        rsp_d.out_address = '0;
      end
      CMD_INS_START: begin
        req_d   = req_i;
        pos_d   = cnt_q;
        rd_addr = cnt_m1[AW-1:0];
      end
      CMD_INS_SHIFT: begin
        // move the larger entry up one slot
        we      = 1'b1;
        pos_d   = pos_m1;
        rd_addr = pos_m2[AW-1:0];
      end
      CMD_INS_PUT: begin
        we          = 1'b1;
        wr_data.id  = req_q.entry_id;
        wr_data.key = req_q.address;
        cnt_d       = cnt_q + CW'(1);
        rsp_valid_d = 1'b1;
        rsp_d.status      = StOk;
        rsp_d.out_id      = '0;
        rsp_d.out_address = '0;
      end
      CMD_REM_START: begin
        pos_d   = '0;
        rd_addr = '0;
      end
      CMD_REM_TAKE: begin
        hold_d  = rd_q;
        pos_d   = CW'(1);
        rd_addr = AW'(1);
      end
      CMD_REM_SHIFT: begin
        // move the next entry down one slot
        we      = 1'b1;
        wr_addr = pos_m1[AW-1:0];
        pos_d   = pos_p1;
        rd_addr = pos_p1[AW-1:0];
      end
      CMD_REM_DONE: begin
        cnt_d       = cnt_m1;
        rsp_valid_d = 1'b1;
        rsp_d.status      = StOk;
        rsp_d.out_id      = hold_q.id;
        rsp_d.out_address = hold_q.key;
      end
      default: begin
      end
    endcase
    cnt_ext          = 32'(cnt_d);
    rsp_d.is_empty   = (cnt_d == '0);
    rsp_d.fill_count = cnt_ext[4:0];
  end

  // Entry store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[wr_addr] <= wr_data;
    end
    rd_q <= store_q[rd_addr];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    pos_q  <= pos_d;
    hold_q <= hold_d;
    rsp_q  <= rsp_d;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef ASSERT_OFF
  // The count stays within the store
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");
  // The count only moves together with a result word
  a_cnt_with_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> rsp_valid_q)
    else $error("entry count changed without a result");
  // Insert writes land no further than one slot past the filled entries
  a_ins_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_INS_SHIFT || cmd_i == CMD_INS_PUT) |-> (pos_q <= cnt_q))
    else $error("insert write beyond filled entries");
`endif

endmodule
